@@ rtl/core/gbts_pkg.sv @@
package gbts_pkg;

    localparam int DEPTH_DEFAULT = 4096;

    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 13;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_BACKSPACE = 3'd1,
        CMD_DELETE    = 3'd2,
        CMD_MOVE_TO   = 3'd3,
        CMD_LEFT      = 3'd4,
        CMD_RIGHT     = 3'd5,
        CMD_READ_AT   = 3'd6,
        CMD_ERASE     = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EDGE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_alu_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ER_CLAMP_E,
        S_ER_CLAMP_B,
        S_ER_CNT,
        S_RDIDX,
        S_RDIDX2,
        S_RDMEM,
        S_RDDATA,
        S_SH_RD,
        S_SH_WR,
        S_ERASE,
        S_ERASE2,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/gbts_cmd_if.sv @@
interface gbts_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [gbts_pkg::CMD_W-1:0]   command;
    logic [gbts_pkg::CHAR_W-1:0]  char_in;
    logic [gbts_pkg::POS_W-1:0]   position;
    logic [gbts_pkg::POS_W-1:0]   position_end;

    modport source (output valid, output command, output char_in, output position,
                    output position_end, input ready);
    modport sink (input valid, input command, input char_in, input position,
                  input position_end, output ready);
endinterface

@@ rtl/core/gbts_res_if.sv @@
interface gbts_res_if;
    logic                           valid;
    logic                           ready;
    logic [gbts_pkg::CHAR_W-1:0]    read_char;
    logic [gbts_pkg::STATUS_W-1:0]  status;
    logic [gbts_pkg::POS_W-1:0]     cursor;
    logic [gbts_pkg::POS_W-1:0]     length;

    modport source (output valid, output read_char, output status, output cursor,
                    output length, input ready);
    modport sink (input valid, input read_char, input status, input cursor,
                  input length, output ready);
endinterface

@@ rtl/core/gap_buffer_text_store_core.sv @@
// Channel  Direction  Words carried
// i_cmd    in         command, char_in, position, position_end
// o_res    out        read_char, status, cursor, length
//
// One command word is taken at a time; i_cmd.ready is high only while the sequencer
// is idle. Every command passes the prepare state; an in-range read-at then forms
// the RAM index and reads the byte, and a gap move crosses one byte at a time (RAM
// read, then RAM write). Erase-range clamps its bounds first and widens the gap last.
// The result register frees the input side: a new command is taken while the last
// result still waits on o_res.ready. Reset is synchronous and active low; the text
// RAM needs no clearing, since no command can expose a byte that was never written.
module gap_buffer_text_store_core #(
    parameter int DEPTH = gbts_pkg::DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gbts_cmd_if.sink       i_cmd,
    gbts_res_if.source     o_res
);

    // Pointers are wide enough for DEPTH itself and for any 13-bit position.
    localparam int PW = $clog2(DEPTH + 1);
    localparam int CW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_W   = CW'(1);

    gbts_pkg::t_state r_state, n_state;

    // Latched command word.
    gbts_pkg::t_cmd                r_cmd, n_cmd;
    logic [gbts_pkg::CHAR_W-1:0]   r_ch, n_ch;
    logic [CW-1:0]                 r_pos, n_pos;
    logic [CW-1:0]                 r_pos_end, n_pos_end;

    // Gap state. The text length is kept alongside so that it never has to be derived.
    logic [CW-1:0] r_gs, n_gs;
    logic [CW-1:0] r_ge, n_ge;
    logic [CW-1:0] r_len, n_len;

    // Working registers of the sequencer.
    logic [CW-1:0]   r_target, n_target;
    logic [CW-1:0]   r_e, n_e;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_tmp, n_tmp;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_left, n_left;
    gbts_pkg::t_status           r_status, n_status;
    logic [gbts_pkg::CHAR_W-1:0] r_rd, n_rd;

    // Result register.
    logic                          r_out_valid;
    logic [gbts_pkg::CHAR_W-1:0]   r_out_rd;
    gbts_pkg::t_status             r_out_status;
    logic [gbts_pkg::POS_W-1:0]    r_out_cursor;
    logic [gbts_pkg::POS_W-1:0]    r_out_length;

    logic accept;
    logic out_load;

    // Shared arithmetic unit.
    gbts_pkg::t_alu_op    alu_op;
    logic [CW-1:0]        alu_a;
    logic [CW-1:0]        alu_b;
    logic [CW-1:0]        alu_res;
    gbts_pkg::t_alu_flags alu_flags;

    // Text RAM ports.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [gbts_pkg::CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [gbts_pkg::CHAR_W-1:0] ram_rdata;

    // Pointer steps for the byte-by-byte gap move.
    logic [CW-1:0] gs_inc, gs_dec, ge_inc, ge_dec, len_inc, len_dec;

    assign gs_inc  = r_gs + ONE_W;
    assign gs_dec  = r_gs - ONE_W;
    assign ge_inc  = r_ge + ONE_W;
    assign ge_dec  = r_ge - ONE_W;
    assign len_inc = r_len + ONE_W;
    assign len_dec = r_len - ONE_W;

    gbts_alu #(
        .W (CW)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    gbts_ram #(
        .WIDTH (gbts_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready = (r_state == gbts_pkg::S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // The result register can take a new word when it is empty or being drained.
    assign out_load = (r_state == gbts_pkg::S_DONE) && (!r_out_valid || o_res.ready);

    // Operand selection for the shared unit. Each state asks one question of it.
    always_comb begin
        alu_op = gbts_pkg::ALU_SUB;
        alu_a  = r_gs;
        alu_b  = r_target;
        case (r_state)
            gbts_pkg::S_PREP: begin
                case (r_cmd)
                    gbts_pkg::CMD_INSERT: begin
                        alu_a = r_len;
                        alu_b = DEPTH_W;
                    end
                    gbts_pkg::CMD_BACKSPACE,
                    gbts_pkg::CMD_LEFT: begin
                        alu_a = r_gs;
                        alu_b = ONE_W;
                    end
                    gbts_pkg::CMD_DELETE: begin
                        alu_a = r_ge;
                        alu_b = DEPTH_W;
                    end
                    gbts_pkg::CMD_RIGHT: begin
                        alu_a = r_gs;
                        alu_b = r_len;
                    end
                    gbts_pkg::CMD_ERASE: begin
                        alu_a = r_pos;
                        alu_b = r_pos_end;
                    end
                    default: begin
                        alu_a = r_pos;
                        alu_b = r_len;
                    end
                endcase
            end
            gbts_pkg::S_ER_CLAMP_E: begin
                alu_a = r_e;
                alu_b = r_len;
            end
            gbts_pkg::S_ER_CLAMP_B: begin
                alu_a = r_target;
                alu_b = r_len;
            end
            gbts_pkg::S_ER_CNT: begin
                alu_a = r_e;
                alu_b = r_target;
            end
            gbts_pkg::S_RDIDX: begin
                alu_a = r_pos;
                alu_b = r_gs;
            end
            gbts_pkg::S_RDIDX2: begin
                alu_op = gbts_pkg::ALU_ADD;
                alu_a  = r_ge;
                alu_b  = r_tmp;
            end
            gbts_pkg::S_ERASE: begin
                alu_op = gbts_pkg::ALU_ADD;
                alu_a  = r_ge;
                alu_b  = r_cnt;
            end
            gbts_pkg::S_ERASE2: begin
                alu_a = r_len;
                alu_b = r_cnt;
            end
            default: begin
                alu_a = r_gs;
                alu_b = r_target;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbts_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = gbts_pkg::S_PREP;
                end
            end
            gbts_pkg::S_PREP: begin
                case (r_cmd)
                    gbts_pkg::CMD_MOVE_TO: n_state = gbts_pkg::S_SH_RD;
                    gbts_pkg::CMD_LEFT: begin
                        n_state = alu_flags.lt ? gbts_pkg::S_DONE : gbts_pkg::S_SH_RD;
                    end
                    gbts_pkg::CMD_RIGHT: begin
                        n_state = alu_flags.lt ? gbts_pkg::S_SH_RD : gbts_pkg::S_DONE;
                    end
                    gbts_pkg::CMD_READ_AT: begin
                        n_state = alu_flags.lt ? gbts_pkg::S_RDIDX : gbts_pkg::S_DONE;
                    end
                    gbts_pkg::CMD_ERASE: n_state = gbts_pkg::S_ER_CLAMP_E;
                    default:             n_state = gbts_pkg::S_DONE;
                endcase
            end
            gbts_pkg::S_ER_CLAMP_E: n_state = gbts_pkg::S_ER_CLAMP_B;
            gbts_pkg::S_ER_CLAMP_B: n_state = gbts_pkg::S_ER_CNT;
            gbts_pkg::S_ER_CNT:     n_state = gbts_pkg::S_SH_RD;
            gbts_pkg::S_RDIDX: begin
                n_state = alu_flags.lt ? gbts_pkg::S_RDMEM : gbts_pkg::S_RDIDX2;
            end
            gbts_pkg::S_RDIDX2: n_state = gbts_pkg::S_RDMEM;
            gbts_pkg::S_RDMEM:  n_state = gbts_pkg::S_RDDATA;
            gbts_pkg::S_RDDATA: n_state = gbts_pkg::S_DONE;
            gbts_pkg::S_SH_RD: begin
                if (alu_flags.eq) begin
                    n_state = (r_cmd == gbts_pkg::CMD_ERASE) ? gbts_pkg::S_ERASE
                                                             : gbts_pkg::S_DONE;
                end else begin
                    n_state = gbts_pkg::S_SH_WR;
                end
            end
            gbts_pkg::S_SH_WR:  n_state = gbts_pkg::S_SH_RD;
            gbts_pkg::S_ERASE:  n_state = gbts_pkg::S_ERASE2;
            gbts_pkg::S_ERASE2: n_state = gbts_pkg::S_DONE;
            gbts_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = gbts_pkg::S_IDLE;
                end
            end
            default: n_state = gbts_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and RAM controls.
    always_comb begin
        n_cmd     = r_cmd;
        n_ch      = r_ch;
        n_pos     = r_pos;
        n_pos_end = r_pos_end;
        n_gs      = r_gs;
        n_ge      = r_ge;
        n_len     = r_len;
        n_target  = r_target;
        n_e       = r_e;
        n_cnt     = r_cnt;
        n_tmp     = r_tmp;
        n_idx     = r_idx;
        n_left    = r_left;
        n_status  = r_status;
        n_rd      = r_rd;
        ram_we    = 1'b0;
        ram_waddr = r_gs[AW-1:0];
        ram_wdata = r_ch;
        ram_raddr = r_idx[AW-1:0];
        case (r_state)
            gbts_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd     = gbts_pkg::t_cmd'(i_cmd.command);
                    n_ch      = i_cmd.char_in;
                    n_pos     = CW'(i_cmd.position);
                    n_pos_end = CW'(i_cmd.position_end);
                    n_status  = gbts_pkg::ST_OK;
                    n_rd      = '0;
                end
            end
            gbts_pkg::S_PREP: begin
                case (r_cmd)
                    gbts_pkg::CMD_INSERT: begin
                        if (alu_flags.lt) begin
                            ram_we = 1'b1;
                            n_gs   = gs_inc;
                            n_len  = len_inc;
                        end else begin
                            n_status = gbts_pkg::ST_FULL;
                        end
                    end
                    gbts_pkg::CMD_BACKSPACE: begin
                        if (alu_flags.lt) begin
                            n_status = gbts_pkg::ST_EDGE;
                        end else begin
                            n_gs  = alu_res;
                            n_len = len_dec;
                        end
                    end
                    gbts_pkg::CMD_DELETE: begin
                        if (alu_flags.lt) begin
                            n_ge  = ge_inc;
                            n_len = len_dec;
                        end else begin
                            n_status = gbts_pkg::ST_EDGE;
                        end
                    end
                    gbts_pkg::CMD_MOVE_TO: begin
                        n_target = alu_flags.lt ? r_pos : r_len;
                    end
                    gbts_pkg::CMD_LEFT: begin
                        if (alu_flags.lt) begin
                            n_status = gbts_pkg::ST_EDGE;
                        end else begin
                            n_target = alu_res;
                        end
                    end
                    gbts_pkg::CMD_RIGHT: begin
                        if (alu_flags.lt) begin
                            n_target = gs_inc;
                        end else begin
                            n_status = gbts_pkg::ST_EDGE;
                        end
                    end
                    gbts_pkg::CMD_READ_AT: begin
                        if (!alu_flags.lt) begin
                            n_status = gbts_pkg::ST_RANGE;
                        end
                    end
                    gbts_pkg::CMD_ERASE: begin
                        // Put a reversed range in order.
                        if (alu_flags.lt || alu_flags.eq) begin
                            n_target = r_pos;
                            n_e      = r_pos_end;
                        end else begin
                            n_target = r_pos_end;
                            n_e      = r_pos;
                        end
                    end
                    default: n_status = gbts_pkg::ST_OK;
                endcase
            end
            gbts_pkg::S_ER_CLAMP_E: begin
                if (!alu_flags.lt) begin
                    n_e = r_len;
                end
            end
            gbts_pkg::S_ER_CLAMP_B: begin
                if (!alu_flags.lt) begin
                    n_target = r_len;
                end
            end
            gbts_pkg::S_ER_CNT: n_cnt = alu_res;
            gbts_pkg::S_RDIDX: begin
                // Before the gap the index is the position itself; after it the
                // gap end plus the distance past the cursor.
                if (alu_flags.lt) begin
                    n_idx = r_pos;
                end else begin
                    n_tmp = alu_res;
                end
            end
            gbts_pkg::S_RDIDX2: n_idx = alu_res;
            gbts_pkg::S_RDMEM:  ram_raddr = r_idx[AW-1:0];
            gbts_pkg::S_RDDATA: n_rd = ram_rdata;
            gbts_pkg::S_SH_RD: begin
                // Fetch the byte that crosses the gap next.
                n_left    = !alu_flags.lt;
                ram_raddr = alu_flags.lt ? r_ge[AW-1:0] : gs_dec[AW-1:0];
            end
            gbts_pkg::S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (r_left) begin
                    ram_waddr = ge_dec[AW-1:0];
                    n_gs      = gs_dec;
                    n_ge      = ge_dec;
                end else begin
                    ram_waddr = r_gs[AW-1:0];
                    n_gs      = gs_inc;
                    n_ge      = ge_inc;
                end
            end
            gbts_pkg::S_ERASE:  n_ge  = alu_res;
            gbts_pkg::S_ERASE2: n_len = alu_res;
            default: n_status = r_status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbts_pkg::S_IDLE;
            r_gs        <= '0;
            r_ge        <= DEPTH_W;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_ge    <= n_ge;
            r_len   <= n_len;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_ch      <= n_ch;
        r_pos     <= n_pos;
        r_pos_end <= n_pos_end;
        r_target  <= n_target;
        r_e       <= n_e;
        r_cnt     <= n_cnt;
        r_tmp     <= n_tmp;
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_status  <= n_status;
        r_rd      <= n_rd;
        if (out_load) begin
            r_out_rd     <= r_rd;
            r_out_status <= r_status;
            r_out_cursor <= r_gs[gbts_pkg::POS_W-1:0];
            r_out_length <= r_len[gbts_pkg::POS_W-1:0];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.read_char = r_out_rd;
    assign o_res.status    = r_out_status;
    assign o_res.cursor    = r_out_cursor;
    assign o_res.length    = r_out_length;

    // The gap always lies inside the store.
    a_gap_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gs <= r_ge) && (r_ge <= DEPTH_W))
        else $error("gap pointers out of order");

    // The tracked length always equals the depth less the gap width. An erase widens the
    // gap in S_ERASE before the length catches up, so state S_ERASE2 is left out.
    a_len_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbts_pkg::S_ERASE2) || (r_len == (DEPTH_W - (r_ge - r_gs))))
        else $error("length register disagrees with gap");

    // Once a command is taken the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_cmd.ready)
        else $error("command accepted while previous one in progress");

    // A result is loaded only after the sequencer has finished a command.
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && (r_state == gbts_pkg::S_IDLE)))
        else $error("result register not loaded on completion");

endmodule

@@ rtl/core/gbts_ram.sv @@
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/gbts_alu.sv @@
module gbts_alu #(
    parameter int W = 13
) (
    input  gbts_pkg::t_alu_op    i_op,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    output logic [W-1:0]         o_res,
    output gbts_pkg::t_alu_flags o_flags
);

    // One subtractor serves both the difference and the less-than flag.
    logic [W:0] diff;

    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        case (i_op)
            gbts_pkg::ALU_ADD: o_res = i_a + i_b;
            gbts_pkg::ALU_SUB: o_res = diff[W-1:0];
            default:           o_res = diff[W-1:0];
        endcase
        o_flags.lt = diff[W];
        o_flags.eq = (i_a == i_b);
    end

endmodule

@@ dv/gap_buffer_text_store_core_test.sv @@
`timescale 1ns / 1ps

import gbts_pkg::*;

typedef struct {
    logic [CHAR_W-1:0] read_char;
    t_status           status;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  length;
} text_result_t;

// Keeps a private copy of the gap buffer and predicts the result word of each command.
class text_edit_tracker;
    logic [CHAR_W-1:0] text_copy [DEPTH_DEFAULT];
    int unsigned       gap_lo;
    int unsigned       gap_hi;
    text_result_t      awaited_results [$];
    int unsigned       faults;

    function new();
        foreach (text_copy[i]) text_copy[i] = '0;
        gap_lo = 0;
        gap_hi = DEPTH_DEFAULT;
        faults = 0;
    endfunction

    function int unsigned text_length();
        return DEPTH_DEFAULT - (gap_hi - gap_lo);
    endfunction

    // Bytes cross the gap one at a time, exactly as the store shifts them.
    function void slide_gap(int unsigned target);
        int unsigned len;
        len = text_length();
        if (target > len) target = len;
        while (gap_lo > target) begin
            gap_lo--;
            gap_hi--;
            if (gap_hi < DEPTH_DEFAULT && gap_lo < DEPTH_DEFAULT)
                text_copy[gap_hi] = text_copy[gap_lo];
        end
        while (gap_lo < target) begin
            if (gap_hi < DEPTH_DEFAULT && gap_lo < DEPTH_DEFAULT)
                text_copy[gap_lo] = text_copy[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    function void note_command(t_cmd op, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos,
                               logic [POS_W-1:0] pos_end);
        text_result_t r;
        int unsigned  len;
        int unsigned  idx;
        int unsigned  b;
        int unsigned  e;
        len = text_length();
        r.read_char = '0;
        r.status = ST_OK;
        case (op)
            CMD_INSERT: begin
                if (gap_lo >= gap_hi || gap_lo >= DEPTH_DEFAULT) begin
                    r.status = ST_FULL;
                end else begin
                    text_copy[gap_lo] = ch;
                    gap_lo++;
                end
            end
            CMD_BACKSPACE: begin
                if (gap_lo == 0) r.status = ST_EDGE;
                else gap_lo--;
            end
            CMD_DELETE: begin
                if (gap_hi >= DEPTH_DEFAULT) r.status = ST_EDGE;
                else gap_hi++;
            end
            CMD_MOVE_TO: slide_gap(pos);
            CMD_LEFT: begin
                if (gap_lo == 0) r.status = ST_EDGE;
                else slide_gap(gap_lo - 1);
            end
            CMD_RIGHT: begin
                if (gap_lo >= len) r.status = ST_EDGE;
                else slide_gap(gap_lo + 1);
            end
            CMD_READ_AT: begin
                if (pos >= len) begin
                    r.status = ST_RANGE;
                end else begin
                    idx = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo);
                    if (idx < DEPTH_DEFAULT) r.read_char = text_copy[idx];
                end
            end
            default: begin
                b = pos;
                e = pos_end;
                if (b > e) begin
                    b = pos_end;
                    e = pos;
                end
                if (e > len) e = len;
                if (b > len) b = len;
                slide_gap(b);
                gap_hi += e - b;
            end
        endcase
        r.cursor = POS_W'(gap_lo);
        r.length = POS_W'(text_length());
        awaited_results.push_back(r);
    endfunction

    function void check_result(logic [CHAR_W-1:0] rc, logic [STATUS_W-1:0] st,
                               logic [POS_W-1:0] cur, logic [POS_W-1:0] len);
        text_result_t want;
        if (awaited_results.size() == 0) begin
            $error("result word with no command outstanding: status %0d cursor %0d length %0d",
                   st, cur, len);
            faults++;
            return;
        end
        want = awaited_results.pop_front();
        if (rc !== want.read_char) begin
            $error("read_char: expected %0d, got %0d", want.read_char, rc);
            faults++;
        end
        if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            faults++;
        end
        if (cur !== want.cursor) begin
            $error("cursor: expected %0d, got %0d", want.cursor, cur);
            faults++;
        end
        if (len !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, len);
            faults++;
        end
    endfunction
endclass

module gap_buffer_text_store_core_test;

    // Upper bound on the run, gap moves and stalls included.
    localparam int unsigned CYCLE_LIMIT  = 10_000_000;
    localparam int unsigned RANDOM_WORDS = 1450;
    // The receiver stops taking result words for a long stretch once this many have arrived.
    localparam int unsigned HOLD_AFTER   = 200;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic i_clk;
    logic i_rst_n;

    gbts_cmd_if cmd_bus ();
    gbts_res_if res_bus ();

    gap_buffer_text_store_core #(
        .DEPTH(DEPTH_DEFAULT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_res  (res_bus)
    );

    text_edit_tracker chk = new();

    // Idling on either side can be switched off for whole stretches of the run.
    bit          sender_gaps_on  = 1'b1;
    bit          reply_stalls_on = 1'b1;
    int unsigned results_seen    = 0;
    int unsigned cycles_run      = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watchdog: a hung handshake or a lost result word ends the run here.
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("gap_buffer_text_store_core: mismatch");
        $finish;
    end

    // Offers one command word, after a random gap, and holds it until the block takes it.
    // The prediction is made at the edge of acceptance, so commands are modelled in order.
    task automatic send_command(t_cmd op, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos,
                                logic [POS_W-1:0] pos_end);
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.command      <= op;
        cmd_bus.char_in      <= ch;
        cmd_bus.position     <= pos;
        cmd_bus.position_end <= pos_end;
        do @(posedge i_clk); while (!(cmd_bus.valid && cmd_bus.ready));
        chk.note_command(op, ch, pos, pos_end);
    endtask

    // Withdraws the command channel and waits for every outstanding result word. It always
    // waits on the clock before it checks, so the next word never lowers and raises valid in one step.
    task automatic wait_until_drained();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (chk.awaited_results.size() != 0);
    endtask

    // Most targets sit close to the cursor, which keeps gap moves short; a few span the
    // whole 13-bit field so that clamping and every position bit are exercised.
    function automatic logic [POS_W-1:0] pick_position(int unsigned len, int unsigned cur);
        int unsigned r;
        int unsigned p;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            p = cur + $urandom_range(0, 32);
            p = (p > 16) ? p - 16 : 0;
        end else if (r < 85) begin
            p = $urandom_range(0, len + 1);
        end else if (r < 95) begin
            p = $urandom_range(0, 8191);
        end else begin
            case ($urandom_range(0, 4))
                0:       p = 0;
                1:       p = len;
                2:       p = DEPTH_DEFAULT - 1;
                3:       p = DEPTH_DEFAULT;
                default: p = 8191;
            endcase
        end
        return POS_W'(p);
    endfunction

    // Result side: a random stall before each word, plus one long hold-off that lets the
    // block fill its result register and then refuse further command words.
    initial begin
        int unsigned pause;
        res_bus.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            pause = reply_stalls_on ? $urandom_range(0, 8) : 0;
            if (results_seen == HOLD_AFTER) pause += HOLD_CYCLES;
            if (pause != 0) begin
                res_bus.ready <= 1'b0;
                for (int unsigned k = 0; k < pause; k++) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
            chk.check_result(res_bus.read_char, res_bus.status, res_bus.cursor, res_bus.length);
            results_seen++;
        end
    end

    initial begin
        t_cmd             op;
        int unsigned      len;
        int unsigned      cur;
        int unsigned      ins_share;
        int unsigned      r;
        int unsigned      span;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] pos_end;

        i_rst_n              <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.command      <= CMD_INSERT;
        cmd_bus.char_in      <= '0;
        cmd_bus.position     <= '0;
        cmd_bus.position_end <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words on the empty store: every refusal at the edges, a read out of
        // range, a move and an erase far beyond the text, then a few bytes of text to read
        // back, edit and erase with a reversed range and with an end past the text.
        send_command(CMD_BACKSPACE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_DELETE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_LEFT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_RIGHT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_MOVE_TO, 8'h00, 13'd8191, 13'd0);
        send_command(CMD_ERASE, 8'h00, 13'd8191, 13'd0);
        send_command(CMD_INSERT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'hFF, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'hA5, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'h5A, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'h01, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'h80, 13'd0, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd5, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd6, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd8191, 13'd0);
        send_command(CMD_MOVE_TO, 8'h00, 13'd2, 13'd0);
        send_command(CMD_LEFT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_RIGHT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_DELETE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_BACKSPACE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_ERASE, 8'h00, 13'd3, 13'd1);
        send_command(CMD_ERASE, 8'h00, 13'd1, 13'd8191);
        send_command(CMD_MOVE_TO, 8'h00, 13'd0, 13'd0);

        // Random editing. The share of inserts follows the text length, which keeps the
        // text long enough to read from yet short enough for cheap gap moves.
        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 100 == 0) begin
                sender_gaps_on  = ($urandom_range(0, 3) != 0);
                reply_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_WORDS / 2) wait_until_drained();
            len = chk.text_length();
            cur = chk.gap_lo;
            ins_share = (len < 32) ? 55 : ((len > 300) ? 20 : 35);
            if ($urandom_range(0, 99) < ins_share) begin
                op = CMD_INSERT;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12)      op = CMD_BACKSPACE;
                else if (r < 24) op = CMD_DELETE;
                else if (r < 40) op = CMD_MOVE_TO;
                else if (r < 52) op = CMD_LEFT;
                else if (r < 64) op = CMD_RIGHT;
                else if (r < 85) op = CMD_READ_AT;
                else             op = CMD_ERASE;
            end
            pos = pick_position(len, cur);
            pos_end = POS_W'($urandom());
            if (op == CMD_ERASE) begin
                r = $urandom_range(0, 99);
                span = $urandom_range(0, 12);
                if (r < 60)      pos_end = pos + POS_W'(span);
                else if (r < 80) pos_end = (pos > span) ? pos - POS_W'(span) : '0;
                else if (r < 90) pos_end = POS_W'($urandom());
                else             pos_end = pos;
            end
            send_command(op, CHAR_W'($urandom()), pos, pos_end);
        end

        wait_until_drained();
        sender_gaps_on  = 1'b1;
        reply_stalls_on = 1'b1;

        // Edges at both ends of whatever text is left, reads at and past the largest
        // index, and one erase past the end that empties the store again.
        send_command(CMD_INSERT, 8'h3C, 13'd0, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd4095, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd4096, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_RIGHT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_MOVE_TO, 8'h00, 13'd8191, 13'd0);
        send_command(CMD_RIGHT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_DELETE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'hC3, 13'd0, 13'd0);
        send_command(CMD_MOVE_TO, 8'h00, 13'd0, 13'd0);
        send_command(CMD_LEFT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_BACKSPACE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_DELETE, 8'h00, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'h7E, 13'd0, 13'd0);
        send_command(CMD_INSERT, 8'h81, 13'd0, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd0, 13'd0);
        send_command(CMD_ERASE, 8'h00, 13'd8191, 13'd0);
        send_command(CMD_READ_AT, 8'h00, 13'd0, 13'd0);

        // Every result word is in; a short quiet spell catches any spurious extra word.
        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (chk.faults == 0) begin
            $display("gap_buffer_text_store_core: match");
        end else begin
            $display("gap_buffer_text_store_core: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/gbts_pkg.sv
rtl/core/gbts_cmd_if.sv
rtl/core/gbts_res_if.sv
rtl/core/gbts_ram.sv
rtl/core/gbts_alu.sv
rtl/core/gap_buffer_text_store_core.sv
dv/gap_buffer_text_store_core_test.sv
